// ===== design/resp_request_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// resp_request_parser_unit assertion macros
// Shared concurrent assertion forms clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_PARSER_UNIT_DEFINES_SVH
`define RESP_REQUEST_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define RRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rrp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrp_pkg
// Types and constants of the multibulk request parser.
// ----------------------------------------------------------------------------
package rrp_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ARG_END = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [2:0] ERR_BAD_STAR    = 3'd0;
    localparam logic [2:0] ERR_BAD_COUNT   = 3'd1;
    localparam logic [2:0] ERR_BAD_DOLLAR  = 3'd2;
    localparam logic [2:0] ERR_BAD_LENGTH  = 3'd3;
    localparam logic [2:0] ERR_BAD_TRAILER = 3'd4;

    // configuration registers
    localparam int         CFG_IDX_W    = 1;
    localparam int         CFG_DATA_W   = 32;
    localparam logic [0:0] CFG_MAX_ARGS = 1'd0;
    localparam logic [0:0] CFG_MAX_LEN  = 1'd1;
    localparam int         MAX_ARGS_W   = 21;
    localparam logic [MAX_ARGS_W-1:0] MAX_ARGS_RST = 21'd1024;
    localparam logic [CFG_DATA_W-1:0] MAX_LEN_RST  = 32'd536870912;

    // result field widths
    localparam int IDX_W     = 20;
    localparam int LEN_OUT_W = 32;

    // ASCII
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // header number accumulator: saturates once above 2^NUM_CAP_LOG
    localparam int NUM_CAP_LOG = 40;
    localparam int NUM_W       = NUM_CAP_LOG + 4;

    // input queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic       clear;
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic       is_star;
        logic       is_dollar;
        logic       is_upper;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_t;

endpackage

// ===== design/resp_request_parser_unit.sv =====
// ----------------------------------------------------------------------------
// resp_request_parser_unit
// Byte-serial multibulk request parser: front queue plus parser back end.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+----------------------------------------------
//  s_       | s_valid/s_ready   | operation, in_byte
//  m_       | m_valid/m_ready   | result_kind, data_byte, arg_index,
//           |                   | arg_length, request_done, error_code
//  cfg_     | cfg_wr_en         | cfg_index, cfg_wr_data
//
//  One byte per cycle sustained while m_ready is held high; the parser
//  updates its state once per byte (times-ten accumulate by shift and add).
//  An input transaction reaches the result through two registers: queue,
//  then output register.
//  Reset is synchronous; no clearing pass.
//  A stalled m_ side fills the two-entry input queue, then drops s_ready.
// ----------------------------------------------------------------------------
module resp_request_parser_unit
    import rrp_pkg::*;
#(
    parameter int LENGTH_WIDTH = 32,
    parameter int COUNT_WIDTH  = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [7:0]            s_in_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic [7:0]            m_data_byte,
    output logic [IDX_W-1:0]      m_arg_index,
    output logic [LEN_OUT_W-1:0]  m_arg_length,
    output logic                  m_request_done,
    output logic [2:0]            m_error_code
);

    q_t   q_item;
    logic q_pop;

    rrp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_in_byte   (s_in_byte),
        .q_out       (q_item),
        .q_pop       (q_pop)
    );

    rrp_back #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .q_in           (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_data_byte    (m_data_byte),
        .m_arg_index    (m_arg_index),
        .m_arg_length   (m_arg_length),
        .m_request_done (m_request_done),
        .m_error_code   (m_error_code)
    );

endmodule

// ===== design/rrp_front.sv =====
// ----------------------------------------------------------------------------
// rrp_front
// Accepts input transactions, classifies the byte and queues the item.
// ----------------------------------------------------------------------------
module rrp_front
    import rrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic [7:0] s_in_byte,
    output q_t         q_out,
    input  logic       q_pop
);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    item_t              in_item;
    logic               push;
    logic               pop;

    always_comb begin
        in_item.clear     = s_operation;
        in_item.data      = s_in_byte;
        in_item.is_cr     = (s_in_byte == CH_CR);
        in_item.is_lf     = (s_in_byte == CH_LF);
        in_item.is_digit  = (s_in_byte >= CH_ZERO) && (s_in_byte <= CH_NINE);
        in_item.is_star   = (s_in_byte == CH_STAR);
        in_item.is_dollar = (s_in_byte == CH_DOLLAR);
        in_item.is_upper  = (s_in_byte >= CH_UPPER_A) && (s_in_byte <= CH_UPPER_Z);
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (count_reg != '0);

    assign q_out.valid = (count_reg != '0);
    assign q_out.item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/rrp_back.sv =====
// ----------------------------------------------------------------------------
// rrp_back
// Parser state machine, limit registers and result output register.
// ----------------------------------------------------------------------------
module rrp_back
    import rrp_pkg::*;
#(
    parameter int LENGTH_WIDTH = 32,
    parameter int COUNT_WIDTH  = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  q_t                    q_in,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic [7:0]            m_data_byte,
    output logic [IDX_W-1:0]      m_arg_index,
    output logic [LEN_OUT_W-1:0]  m_arg_length,
    output logic                  m_request_done,
    output logic [2:0]            m_error_code
);

    localparam logic [1:0] PH_COUNT  = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_STUCK  = 2'd3;

    localparam logic [NUM_W-1:0] NUM_CAP   = NUM_W'(1) << NUM_CAP_LOG;
    localparam logic [NUM_W-1:0] CNT_LIMIT = NUM_W'(1) << COUNT_WIDTH;
    localparam logic [NUM_W-1:0] LEN_MASK  = (NUM_W'(1) << LENGTH_WIDTH) - NUM_W'(1);

    logic [MAX_ARGS_W-1:0]   max_args_reg;
    logic [CFG_DATA_W-1:0]   max_len_reg;

    logic [1:0]              phase_reg, phase_next;
    logic                    started_reg, started_next;
    logic                    prefix_reg, prefix_next;
    logic                    digits_reg, digits_next;
    logic                    bad_reg, bad_next;
    logic                    cr_reg, cr_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic                    big_reg, big_next;
    logic [COUNT_WIDTH:0]    args_left_reg, args_left_next;
    logic [COUNT_WIDTH-1:0]  arg_cnt_reg, arg_cnt_next;
    logic [LENGTH_WIDTH-1:0] bulk_len_reg, bulk_len_next;
    logic [LENGTH_WIDTH-1:0] pay_cnt_reg, pay_cnt_next;
    logic                    trl_pos_reg, trl_pos_next;
    logic                    trl_bad_reg, trl_bad_next;

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_kind_reg;
    logic [7:0]              out_data_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [LEN_OUT_W-1:0]    out_len_reg;
    logic                    out_done_reg;
    logic [2:0]              out_code_reg;

    logic                    take;
    item_t                   it;
    logic                    emit;
    logic [1:0]              emit_kind;
    logic [7:0]              emit_data;
    logic [LEN_OUT_W-1:0]    emit_len;
    logic                    emit_done;
    logic [2:0]              emit_code;

    logic [IDX_W+COUNT_WIDTH-1:0]      idx_ext;
    logic [LEN_OUT_W+LENGTH_WIDTH-1:0] len_ext;
    logic                    counting;
    logic                    want_hit;
    logic                    bad_num;
    logic                    last_arg;
    logic [NUM_W-1:0]        num_step;

    assign it       = q_in.item;
    assign take     = q_in.valid && (!out_valid_reg || m_ready);
    assign q_pop    = take;
    assign idx_ext  = {{IDX_W{1'b0}}, arg_cnt_reg};
    assign len_ext  = {{LEN_OUT_W{1'b0}}, bulk_len_reg};
    assign counting = (phase_reg == PH_COUNT);
    assign want_hit = counting ? it.is_star : it.is_dollar;
    assign bad_num  = !digits_reg || bad_reg || big_reg;
    assign last_arg = (args_left_reg <= (COUNT_WIDTH+1)'(1));
    assign num_step = (num_reg << 3) + (num_reg << 1) + NUM_W'(it.data[3:0]);

    always_comb begin
        phase_next     = phase_reg;
        started_next   = started_reg;
        prefix_next    = prefix_reg;
        digits_next    = digits_reg;
        bad_next       = bad_reg;
        cr_next        = cr_reg;
        num_next       = num_reg;
        big_next       = big_reg;
        args_left_next = args_left_reg;
        arg_cnt_next   = arg_cnt_reg;
        bulk_len_next  = bulk_len_reg;
        pay_cnt_next   = pay_cnt_reg;
        trl_pos_next   = trl_pos_reg;
        trl_bad_next   = trl_bad_reg;
        emit           = 1'b0;
        emit_kind      = KIND_ERROR;
        emit_data      = '0;
        emit_len       = '0;
        emit_done      = 1'b0;
        emit_code      = '0;

        if (take) begin
            if (it.clear) begin
                phase_next     = PH_COUNT;
                started_next   = 1'b0;
                prefix_next    = 1'b0;
                digits_next    = 1'b0;
                bad_next       = 1'b0;
                cr_next        = 1'b0;
                num_next       = '0;
                big_next       = 1'b0;
                args_left_next = '0;
                arg_cnt_next   = '0;
                bulk_len_next  = '0;
                pay_cnt_next   = '0;
                trl_pos_next   = 1'b0;
                trl_bad_next   = 1'b0;
            end else begin
                case (phase_reg)
                    PH_STUCK: begin
                    end
                    PH_DATA: begin
                        if (pay_cnt_reg < bulk_len_reg) begin
                            pay_cnt_next = pay_cnt_reg + LENGTH_WIDTH'(1);
                            emit         = 1'b1;
                            emit_kind    = KIND_PAYLOAD;
                            emit_data    = (arg_cnt_reg == '0 && it.is_upper) ?
                                           (it.data | CASE_BIT) : it.data;
                        end else if (!trl_pos_reg) begin
                            trl_pos_next = 1'b1;
                            trl_bad_next = !it.is_cr;
                        end else if (trl_bad_reg || !it.is_lf) begin
                            phase_next = PH_STUCK;
                            emit       = 1'b1;
                            emit_kind  = KIND_ERROR;
                            emit_code  = ERR_BAD_TRAILER;
                        end else begin
                            emit         = 1'b1;
                            emit_kind    = KIND_ARG_END;
                            emit_len     = len_ext[LEN_OUT_W-1:0];
                            emit_done    = last_arg;
                            trl_pos_next = 1'b0;
                            trl_bad_next = 1'b0;
                            pay_cnt_next = '0;
                            started_next = 1'b0;
                            prefix_next  = 1'b0;
                            digits_next  = 1'b0;
                            bad_next     = 1'b0;
                            cr_next      = 1'b0;
                            num_next     = '0;
                            big_next     = 1'b0;
                            if (last_arg) begin
                                args_left_next = '0;
                                arg_cnt_next   = '0;
                                phase_next     = PH_COUNT;
                            end else begin
                                args_left_next = args_left_reg - (COUNT_WIDTH+1)'(1);
                                arg_cnt_next   = arg_cnt_reg + COUNT_WIDTH'(1);
                                phase_next     = PH_LENGTH;
                            end
                        end
                    end
                    default: begin
                        if (cr_reg && it.is_lf) begin
                            // header line complete
                            if (!started_reg || !prefix_reg) begin
                                phase_next = PH_STUCK;
                                emit       = 1'b1;
                                emit_kind  = KIND_ERROR;
                                emit_code  = counting ? ERR_BAD_STAR : ERR_BAD_DOLLAR;
                            end else if (counting) begin
                                if (bad_num || num_reg == '0 ||
                                    num_reg > NUM_W'(max_args_reg) ||
                                    num_reg > CNT_LIMIT) begin
                                    phase_next = PH_STUCK;
                                    emit       = 1'b1;
                                    emit_kind  = KIND_ERROR;
                                    emit_code  = ERR_BAD_COUNT;
                                end else begin
                                    args_left_next = num_reg[COUNT_WIDTH:0];
                                    arg_cnt_next   = '0;
                                    phase_next     = PH_LENGTH;
                                end
                            end else begin
                                if (bad_num || num_reg > NUM_W'(max_len_reg) ||
                                    num_reg > LEN_MASK) begin
                                    phase_next = PH_STUCK;
                                    emit       = 1'b1;
                                    emit_kind  = KIND_ERROR;
                                    emit_code  = ERR_BAD_LENGTH;
                                end else begin
                                    bulk_len_next = num_reg[LENGTH_WIDTH-1:0];
                                    pay_cnt_next  = '0;
                                    trl_pos_next  = 1'b0;
                                    trl_bad_next  = 1'b0;
                                    phase_next    = PH_DATA;
                                end
                            end
                            if (!emit) begin
                                started_next = 1'b0;
                                prefix_next  = 1'b0;
                                digits_next  = 1'b0;
                                bad_next     = 1'b0;
                                cr_next      = 1'b0;
                                num_next     = '0;
                                big_next     = 1'b0;
                            end
                        end else begin
                            // lone CR counts as a line byte
                            if (cr_reg) begin
                                if (!started_next) begin
                                    started_next = 1'b1;
                                    prefix_next  = 1'b0;
                                end else begin
                                    bad_next = 1'b1;
                                end
                                cr_next = 1'b0;
                            end
                            if (it.is_cr) begin
                                cr_next = 1'b1;
                            end else if (!started_next) begin
                                started_next = 1'b1;
                                prefix_next  = want_hit;
                            end else if (!it.is_digit) begin
                                bad_next = 1'b1;
                            end else begin
                                digits_next = 1'b1;
                                if (big_reg || num_reg > NUM_CAP) begin
                                    big_next = 1'b1;
                                end else begin
                                    num_next = num_step;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (take) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_args_reg  <= MAX_ARGS_RST;
            max_len_reg   <= MAX_LEN_RST;
            phase_reg     <= PH_COUNT;
            started_reg   <= 1'b0;
            prefix_reg    <= 1'b0;
            digits_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            cr_reg        <= 1'b0;
            num_reg       <= '0;
            big_reg       <= 1'b0;
            args_left_reg <= '0;
            arg_cnt_reg   <= '0;
            bulk_len_reg  <= '0;
            pay_cnt_reg   <= '0;
            trl_pos_reg   <= 1'b0;
            trl_bad_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_ARGS: max_args_reg <= cfg_wr_data[MAX_ARGS_W-1:0];
                    CFG_MAX_LEN:  max_len_reg  <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            prefix_reg    <= prefix_next;
            digits_reg    <= digits_next;
            bad_reg       <= bad_next;
            cr_reg        <= cr_next;
            num_reg       <= num_next;
            big_reg       <= big_next;
            args_left_reg <= args_left_next;
            arg_cnt_reg   <= arg_cnt_next;
            bulk_len_reg  <= bulk_len_next;
            pay_cnt_reg   <= pay_cnt_next;
            trl_pos_reg   <= trl_pos_next;
            trl_bad_reg   <= trl_bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            out_kind_reg <= emit_kind;
            out_data_reg <= emit_data;
            out_idx_reg  <= idx_ext[IDX_W-1:0];
            out_len_reg  <= emit_len;
            out_done_reg <= emit_done;
            out_code_reg <= emit_code;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_kind  = out_kind_reg;
    assign m_data_byte    = out_data_reg;
    assign m_arg_index    = out_idx_reg;
    assign m_arg_length   = out_len_reg;
    assign m_request_done = out_done_reg;
    assign m_error_code   = out_code_reg;

endmodule

// ===== design/rrp_checker.sv =====
// ----------------------------------------------------------------------------
// rrp_checker
// Port-level assertions for resp_request_parser_unit, bound to the top.
// ----------------------------------------------------------------------------
`include "resp_request_parser_unit_defines.svh"

module rrp_checker
    import rrp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [1:0]           m_result_kind,
    input logic [7:0]           m_data_byte,
    input logic [IDX_W-1:0]     m_arg_index,
    input logic [LEN_OUT_W-1:0] m_arg_length,
    input logic                 m_request_done,
    input logic [2:0]           m_error_code
);

    logic [IDX_W+LEN_OUT_W+13:0] m_fields;
    logic                        m_take;
    logic                        m_arg0_byte;
    logic                        m_upper;

    assign m_fields    = {m_result_kind, m_data_byte, m_arg_index, m_arg_length,
                          m_request_done, m_error_code};
    assign m_take      = m_valid && m_ready;
    assign m_arg0_byte = m_valid && (m_result_kind == KIND_PAYLOAD) && (m_arg_index == '0);
    assign m_upper     = (m_data_byte >= CH_UPPER_A) && (m_data_byte <= CH_UPPER_Z);

    // stalled result transaction holds
    `RRP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_fields), "held")

    // parser is stuck after an error, nothing follows right away
    `RRP_ASSERT_NEXT(a_err_stuck, m_take && m_result_kind == KIND_ERROR, !m_valid, "after error")

    `RRP_ASSERT_NOW(a_done_at_end, m_valid && m_request_done, m_result_kind == KIND_ARG_END, "done")

    // command name comes out lowercased
    `RRP_ASSERT_NOW(a_arg0_lower, m_arg0_byte, !m_upper, "uppercase byte in argument 0")

endmodule

bind resp_request_parser_unit rrp_checker u_rrp_checker (.*);

// ===== verif/resp_request_parser_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resp_request_parser_checker
// Watches the byte and result channels of the multibulk request parser,
// tracks the configuration writes and runs its own copy of the parser on
// every accepted byte. Each result transaction is compared field by field
// with the oldest predicted result; the failure count goes to the top.
// ----------------------------------------------------------------------------
module resp_request_parser_checker
    import rrp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_operation,
    input  logic [7:0]            s_in_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [1:0]            m_result_kind,
    input  logic [7:0]            m_data_byte,
    input  logic [IDX_W-1:0]      m_arg_index,
    input  logic [LEN_OUT_W-1:0]  m_arg_length,
    input  logic                  m_request_done,
    input  logic [2:0]            m_error_code,
    output int                    mismatch_count,
    output int                    pending_results,
    output int                    results_checked,
    output int                    arg_ends_seen,
    output int                    requests_seen,
    output int                    errors_seen
);

    localparam int          COUNT_WIDTH  = 20;
    localparam int          LENGTH_WIDTH = 32;
    localparam logic [63:0] NUM_CAP      = 64'd1 << NUM_CAP_LOG;
    localparam logic [63:0] COUNT_LIMIT  = 64'd1 << COUNT_WIDTH;
    localparam logic [63:0] LENGTH_MAX   = (64'd1 << LENGTH_WIDTH) - 64'd1;

    typedef enum logic [1:0] {
        PH_COUNT_LINE,
        PH_LENGTH_LINE,
        PH_PAYLOAD,
        PH_STUCK
    } parse_phase_e;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           data;
        logic [IDX_W-1:0]     arg_idx;
        logic [LEN_OUT_W-1:0] arg_len;
        logic                 done;
        logic [2:0]           code;
    } parse_result_t;

    parse_result_t parse_results_q[$];

    logic [MAX_ARGS_W-1:0] max_args_reg;
    logic [CFG_DATA_W-1:0] max_len_reg;

    parse_phase_e          phase;
    logic                  line_started, prefix_ok, digits_seen, line_bad, prev_was_cr;
    logic [63:0]           number_value;
    logic                  number_big;
    logic [MAX_ARGS_W-1:0] args_left;
    logic [IDX_W-1:0]      arg_counter;
    logic [31:0]           bulk_length, payload_count;
    logic                  trailer_pos, trailer_bad;

    task automatic reset_line();
        line_started = 1'b0;
        prefix_ok    = 1'b0;
        digits_seen  = 1'b0;
        line_bad     = 1'b0;
        prev_was_cr  = 1'b0;
        number_value = '0;
        number_big   = 1'b0;
    endtask

    task automatic reset_parser();
        reset_line();
        phase         = PH_COUNT_LINE;
        args_left     = '0;
        arg_counter   = '0;
        bulk_length   = '0;
        payload_count = '0;
        trailer_pos   = 1'b0;
        trailer_bad   = 1'b0;
    endtask

    function automatic parse_result_t make_result(input logic [1:0] kind,
                                                  input logic [7:0] data,
                                                  input logic [31:0] len,
                                                  input logic done,
                                                  input logic [2:0] code);
        parse_result_t r;
        r.kind    = kind;
        r.data    = data;
        r.arg_idx = arg_counter;
        r.arg_len = len;
        r.done    = done;
        r.code    = code;
        return r;
    endfunction

    task automatic take_line_byte(input logic [7:0] c, input logic [7:0] want);
        if (!line_started) begin
            line_started = 1'b1;
            prefix_ok    = (c == want);
        end else if (c < CH_ZERO || c > CH_NINE) begin
            line_bad = 1'b1;
        end else begin
            digits_seen = 1'b1;
            if (number_big || number_value > NUM_CAP)
                number_big = 1'b1;
            else
                number_value = number_value * 10 + 64'(c - CH_ZERO);
        end
    endtask

    task automatic close_line(output logic hit, output parse_result_t r);
        logic        counting;
        logic        bad_num;
        logic [63:0] v;
        counting = (phase == PH_COUNT_LINE);
        bad_num  = !digits_seen || line_bad || number_big;
        v        = number_value;
        hit      = 1'b0;
        r        = '0;
        if (!line_started || !prefix_ok) begin
            phase = PH_STUCK;
            hit   = 1'b1;
            r     = make_result(KIND_ERROR, 8'd0, 32'd0, 1'b0,
                                counting ? ERR_BAD_STAR : ERR_BAD_DOLLAR);
        end else if (counting) begin
            if (bad_num || v == 0 || v > 64'(max_args_reg) || v > COUNT_LIMIT) begin
                phase = PH_STUCK;
                hit   = 1'b1;
                r     = make_result(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_BAD_COUNT);
            end else begin
                args_left   = v[MAX_ARGS_W-1:0];
                arg_counter = '0;
                phase       = PH_LENGTH_LINE;
                reset_line();
            end
        end else begin
            if (bad_num || v > 64'(max_len_reg) || v > LENGTH_MAX) begin
                phase = PH_STUCK;
                hit   = 1'b1;
                r     = make_result(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_BAD_LENGTH);
            end else begin
                bulk_length   = v[31:0];
                payload_count = '0;
                trailer_pos   = 1'b0;
                trailer_bad   = 1'b0;
                phase         = PH_PAYLOAD;
                reset_line();
            end
        end
    endtask

    task automatic parse_byte(input logic op, input logic [7:0] c,
                              output logic hit, output parse_result_t r);
        logic [7:0] want;
        logic [7:0] d;
        logic       done;
        hit = 1'b0;
        r   = '0;
        if (op) begin
            reset_parser();
        end else if (phase == PH_STUCK) begin
        end else if (phase == PH_PAYLOAD) begin
            if (payload_count < bulk_length) begin
                d = c;
                if (arg_counter == 0 && c >= CH_UPPER_A && c <= CH_UPPER_Z)
                    d = c | CASE_BIT;
                payload_count++;
                hit = 1'b1;
                r   = make_result(KIND_PAYLOAD, d, 32'd0, 1'b0, 3'd0);
            end else if (!trailer_pos) begin
                trailer_bad = (c != CH_CR);
                trailer_pos = 1'b1;
            end else if (trailer_bad || c != CH_LF) begin
                phase = PH_STUCK;
                hit   = 1'b1;
                r     = make_result(KIND_ERROR, 8'd0, 32'd0, 1'b0, ERR_BAD_TRAILER);
            end else begin
                done = (args_left <= 1);
                hit  = 1'b1;
                r    = make_result(KIND_ARG_END, 8'd0, bulk_length, done, 3'd0);
                trailer_pos   = 1'b0;
                trailer_bad   = 1'b0;
                payload_count = '0;
                reset_line();
                if (done) begin
                    args_left   = '0;
                    arg_counter = '0;
                    phase       = PH_COUNT_LINE;
                end else begin
                    args_left--;
                    arg_counter++;
                    phase = PH_LENGTH_LINE;
                end
            end
        end else begin
            want = (phase == PH_COUNT_LINE) ? CH_STAR : CH_DOLLAR;
            if (prev_was_cr && c == CH_LF) begin
                close_line(hit, r);
            end else begin
                if (prev_was_cr) begin
                    take_line_byte(CH_CR, want);
                    prev_was_cr = 1'b0;
                end
                if (c == CH_CR)
                    prev_was_cr = 1'b1;
                else
                    take_line_byte(c, want);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin : track
        parse_result_t observed;
        parse_result_t predicted;
        logic          produced;
        if (!aresetn) begin
            reset_parser();
            max_args_reg = MAX_ARGS_RST;
            max_len_reg  = MAX_LEN_RST;
            parse_results_q.delete();
            mismatch_count  = 0;
            pending_results = 0;
            results_checked = 0;
            arg_ends_seen   = 0;
            requests_seen   = 0;
            errors_seen     = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_MAX_ARGS)
                    max_args_reg = cfg_wr_data[MAX_ARGS_W-1:0];
                else if (cfg_index == CFG_MAX_LEN)
                    max_len_reg = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                observed.kind    = m_result_kind;
                observed.data    = m_data_byte;
                observed.arg_idx = m_arg_index;
                observed.arg_len = m_arg_length;
                observed.done    = m_request_done;
                observed.code    = m_error_code;
                results_checked++;
                if (observed.kind == KIND_ARG_END) arg_ends_seen++;
                if (observed.kind == KIND_ARG_END && observed.done) requests_seen++;
                if (observed.kind == KIND_ERROR) errors_seen++;
                if (parse_results_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, observed);
                end else begin
                    predicted = parse_results_q.pop_front();
                    check_field("result_kind", predicted.kind, observed.kind);
                    check_field("data_byte", predicted.data, observed.data);
                    check_field("arg_index", predicted.arg_idx, observed.arg_idx);
                    check_field("arg_length", predicted.arg_len, observed.arg_len);
                    check_field("request_done", predicted.done, observed.done);
                    check_field("error_code", predicted.code, observed.code);
                end
            end
            if (s_valid && s_ready) begin
                parse_byte(s_operation, s_in_byte, produced, predicted);
                if (produced)
                    parse_results_q.push_back(predicted);
            end
            pending_results = parse_results_q.size();
        end
    end

endmodule

// ===== verif/resp_request_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resp_request_parser_unit_tb
// Feeds multibulk requests byte by byte into the parser: a short directed
// sequence, then random requests with random content, broken headers,
// bad trailers, truncations, noise and clears, under several limit
// settings. Both channels idle in random bursts; a checker predicts results.
// ----------------------------------------------------------------------------
module resp_request_parser_unit_tb;
    import rrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_operation;
    logic [7:0]            s_in_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_result_kind;
    logic [7:0]            m_data_byte;
    logic [IDX_W-1:0]      m_arg_index;
    logic [LEN_OUT_W-1:0]  m_arg_length;
    logic                  m_request_done;
    logic [2:0]            m_error_code;

    int mismatch_count, pending_results, results_checked;
    int arg_ends_seen, requests_seen, errors_seen;

    logic [8:0]  byte_stream[$];
    int          items_sent;
    int          settings_applied;
    int          gap_pct;
    int          stall_pct;
    int          stall_left;
    int          quiet_cycles;
    logic [63:0] cur_max_args;
    logic [63:0] cur_max_len;

    resp_request_parser_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_data_byte    (m_data_byte),
        .m_arg_index    (m_arg_index),
        .m_arg_length   (m_arg_length),
        .m_request_done (m_request_done),
        .m_error_code   (m_error_code)
    );

    resp_request_parser_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_data_byte     (m_data_byte),
        .m_arg_index     (m_arg_index),
        .m_arg_length    (m_arg_length),
        .m_request_done  (m_request_done),
        .m_error_code    (m_error_code),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .arg_ends_seen   (arg_ends_seen),
        .requests_seen   (requests_seen),
        .errors_seen     (errors_seen)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // result side backpressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_stream.push_back({1'b0, b});
    endtask

    task automatic push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic push_num(input logic [63:0] v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_clear();
        byte_stream.push_back({1'b1, 8'($urandom_range(255))});
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(3))
            0: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            1: return 8'($urandom_range(8'h61, 8'h7A));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_in_byte   <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic flush_stream();
        logic [8:0] item;
        while (byte_stream.size() != 0) begin
            item = byte_stream.pop_front();
            send_item(item[8], item[7:0]);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic apply_limits(input logic [63:0] max_args, input logic [63:0] max_len);
        logic [CFG_DATA_W-1:0] word;
        drain_results();
        repeat (4) @(negedge aclk);
        word = $urandom;
        word[MAX_ARGS_W-1:0] = max_args[MAX_ARGS_W-1:0];
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_MAX_ARGS;
        cfg_wr_data <= word;
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_MAX_LEN;
        cfg_wr_data <= max_len[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        cur_max_args = max_args;
        cur_max_len  = max_len;
        settings_applied++;
    endtask

    // one request, well formed or broken, followed by a clear when needed
    task automatic gen_request();
        int          n;
        int          header_fault;
        int          len_pick;
        int          cut;
        logic [63:0] len;
        logic        abandon;
        logic        needs_clear;
        abandon     = 1'b0;
        needs_clear = 1'b0;
        n = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        header_fault = $urandom_range(24);
        case (header_fault)
            0: push_crlf();
            1: begin
                push_byte(8'($urandom_range(255)));
                push_num(64'(n));
                push_crlf();
            end
            2: begin
                push_byte(CH_STAR);
                push_byte(CH_CR);
                push_num(64'(n));
                push_crlf();
            end
            3: begin
                push_byte(CH_STAR);
                repeat ($urandom_range(13, 20)) push_byte(CH_NINE);
                push_crlf();
            end
            4: begin
                push_byte(CH_STAR);
                push_num(64'd0);
                push_crlf();
            end
            5: begin
                push_byte(CH_STAR);
                push_num(cur_max_args + 64'd1);
                push_crlf();
            end
            6: begin
                push_byte(CH_STAR);
                push_crlf();
            end
            7: begin
                push_byte(CH_STAR);
                push_num(64'(n));
                push_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
                push_crlf();
            end
            8: begin
                push_byte(CH_STAR);
                push_num((64'd1 << IDX_W) + 64'd1);
                push_crlf();
            end
            9: begin
                push_byte(CH_STAR);
                push_num(cur_max_args);
                push_crlf();
                if (cur_max_args <= 8)
                    n = int'(cur_max_args);
                else
                    needs_clear = 1'b1;
            end
            default: begin
                push_byte(CH_STAR);
                push_num(64'(n));
                push_crlf();
                if (n > cur_max_args) abandon = 1'b1;
            end
        endcase
        if (header_fault <= 8) abandon = 1'b1;

        for (int i = 0; i < n && !abandon; i++) begin
            len_pick = $urandom_range(29);
            if (len_pick == 0) begin
                push_byte(CH_DOLLAR);
                push_num(cur_max_len + 64'd1);
                push_crlf();
                abandon = 1'b1;
            end else if (len_pick == 1) begin
                push_byte(CH_DOLLAR);
                push_byte(CH_CR);
                push_num(64'd1);
                push_crlf();
                abandon = 1'b1;
            end else if (len_pick == 2) begin
                push_byte(CH_DOLLAR);
                repeat ($urandom_range(13, 20)) push_byte(CH_NINE);
                push_crlf();
                abandon = 1'b1;
            end else if (len_pick == 3) begin
                push_byte(8'($urandom_range(255)));
                push_num(64'($urandom_range(3)));
                push_crlf();
                abandon = 1'b1;
            end else begin
                len = ($urandom_range(7) == 0) ? 64'($urandom_range(20, 60))
                                               : 64'($urandom_range(9));
                if (len_pick == 4) len = cur_max_len;
                push_byte(CH_DOLLAR);
                push_num(len);
                push_crlf();
                if (len > cur_max_len) begin
                    abandon = 1'b1;
                end else if (len > 60) begin
                    repeat ($urandom_range(5)) push_byte(payload_byte());
                    abandon = 1'b1;
                end else begin
                    repeat (len) push_byte(payload_byte());
                    if ($urandom_range(29) == 0) begin
                        if ($urandom_range(1)) begin
                            push_byte(8'($urandom_range(255)));
                            push_byte(CH_LF);
                        end else begin
                            push_byte(CH_CR);
                            push_byte(8'($urandom_range(255)));
                        end
                        abandon = 1'b1;
                    end else begin
                        push_crlf();
                    end
                end
            end
        end

        if (!abandon && $urandom_range(11) == 0) begin
            byte_stream[$urandom_range(byte_stream.size() - 1)][7:0] = 8'($urandom_range(255));
            needs_clear = 1'b1;
        end
        if ($urandom_range(14) == 0) begin
            cut = $urandom_range(byte_stream.size() - 1);
            while (byte_stream.size() > cut) void'(byte_stream.pop_back());
            needs_clear = 1'b1;
        end
        if (abandon)
            repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)));
        if (abandon || needs_clear || $urandom_range(7) == 0)
            push_clear();
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
            push_clear();
        end
    endtask

    task automatic run_requests(input int budget, input logic quiet);
        int start;
        start = items_sent;
        if (quiet) begin
            gap_pct    = 0;
            stall_pct  = 0;
            stall_left = 0;
        end
        while (items_sent - start < budget) begin
            if (!quiet && $urandom_range(5) == 0) begin
                gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
            end
            gen_request();
            flush_stream();
            if ($urandom_range(24) == 0) drain_results();
        end
    endtask

    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_MAX_ARGS;
        cfg_wr_data      = '0;
        s_valid          = 1'b0;
        s_operation      = 1'b0;
        s_in_byte        = '0;
        m_ready          = 1'b0;
        stall_left       = 0;
        gap_pct          = 0;
        stall_pct        = 0;
        quiet_cycles     = 0;
        items_sent       = 0;
        settings_applied = 0;
        cur_max_args     = 64'(MAX_ARGS_RST);
        cur_max_len      = 64'(MAX_LEN_RST);
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // two arguments: first lowercased with byte extremes, second kept as is
        push_byte(CH_STAR);
        push_num(64'd2);
        push_crlf();
        push_byte(CH_DOLLAR);
        push_num(64'd3);
        push_crlf();
        push_byte(8'h00);
        push_byte(CH_UPPER_A);
        push_byte(CH_UPPER_Z);
        push_crlf();
        push_byte(CH_DOLLAR);
        push_num(64'd2);
        push_crlf();
        push_byte(8'hFF);
        push_byte(CH_UPPER_Z);
        push_crlf();
        // empty line, then a byte while stuck, then clear
        push_crlf();
        push_byte(8'h78);
        push_clear();
        flush_stream();

        run_requests(200, 1'b0);
        apply_limits(64'd1, 64'd0);
        run_requests(250, 1'b0);
        apply_limits(64'd3, 64'd8);
        run_requests(250, 1'b0);
        apply_limits(64'd1 << IDX_W, 64'hFFFF_FFFF);
        run_requests(300, 1'b0);
        apply_limits(64'($urandom_range(2, 6)), 64'($urandom_range(4, 20)));
        run_requests(300, 1'b0);
        apply_limits(64'(MAX_ARGS_RST), 64'(MAX_LEN_RST));
        run_requests(250, 1'b1);

        drain_results();
        repeat (8) @(negedge aclk);

        $display("run: %0d inputs, %0d results (%0d arg ends, %0d requests, %0d errors)",
                 items_sent, results_checked, arg_ends_seen, requests_seen, errors_seen);
        $display("run: reset limits plus %0d written limit settings, with and without idling",
                 settings_applied);
        if (pending_results != 0)
            $display("%0t: %0d expected results never arrived", $time, pending_results);
        if (mismatch_count == 0 && pending_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
